// ----- hdl/fbis_pkg.sv -----
package fbis_pkg;

    localparam int FRAC_BITS  = 32;
    localparam int WORD_W     = 64;
    localparam int DT_W       = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int PC_W       = 5;
    localparam int DIV_STEPS  = 2 * WORD_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] POS_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] NEG_MAX  = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] ONE_FX   = WORD_W'(64'd1 << FRAC_BITS);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_SVEL     = 3'd1,
        CFG_SPOS     = 3'd2,
        CFG_MASS     = 3'd3,
        CFG_RADIUS   = 3'd4,
        CFG_DRAG     = 3'd5,
        CFG_FIXG     = 3'd6,
        CFG_ISC      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_UADD = 3'd4,
        OP_MUL  = 3'd5,
        OP_DIV  = 3'd6,
        OP_TEST = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        S_P     = 4'd0,
        S_V     = 4'd1,
        S_A     = 4'd2,
        S_T     = 4'd3,
        S_X     = 4'd4,
        S_Y     = 4'd5,
        S_DT    = 4'd6,
        S_DT2   = 4'd7,
        S_DRAG  = 4'd8,
        S_FIXG  = 4'd9,
        S_ISC   = 4'd10,
        S_MASS  = 4'd11,
        S_RAD   = 4'd12,
        S_SPOS  = 4'd13,
        S_SVEL  = 4'd14,
        S_ZERO  = 4'd15
    } src_t;

    typedef enum logic [2:0] {
        D_P    = 3'd0,
        D_V    = 3'd1,
        D_A    = 3'd2,
        D_T    = 3'd3,
        D_X    = 3'd4,
        D_Y    = 3'd5,
        D_DT2  = 3'd6,
        D_NONE = 3'd7
    } dst_t;

    typedef enum logic [2:0] {
        J_NEXT    = 3'd0,
        J_GOTO    = 3'd1,
        J_IFSTOP  = 3'd2,
        J_IFFIXED = 3'd3,
        J_END     = 3'd4
    } jmp_t;

    typedef struct packed {
        op_t              op;
        src_t             src_a;
        src_t             src_b;
        dst_t             dst;
        logic             shift1;
        logic             umul;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } uop_t;

    typedef struct packed {
        logic  capture;
        logic  start;
        logic  load_out;
        op_t   op;
        src_t  src_a;
        src_t  src_b;
        dst_t  dst;
        logic  shift1;
        logic  umul;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic stop;
        logic fixed_mode;
        logic out_free;
    } dp_stat_t;

    localparam logic [PC_W-1:0] PC_INIT = 5'd0;
    localparam logic [PC_W-1:0] PC_STEP = 5'd3;
    localparam logic [PC_W-1:0] PC_TEST = 5'd11;
    localparam logic [PC_W-1:0] PC_FIXG = 5'd17;
    localparam logic [PC_W-1:0] PC_SUB  = 5'd18;
    localparam logic [PC_W-1:0] PC_STOP = 5'd20;

    function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input dst_t d,
                                input logic sh1, input logic um, input jmp_t j,
                                input logic [PC_W-1:0] t);
        uop_t u;
        u.op = op; u.src_a = a; u.src_b = b; u.dst = d;
        u.shift1 = sh1; u.umul = um; u.jmp = j; u.target = t;
        return u;
    endfunction

    // Microprogram for one time step.
    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(OP_LOAD, S_SPOS, S_ZERO, D_P,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd1:  u = mk(OP_LOAD, S_SVEL, S_ZERO, D_V,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd2:  u = mk(OP_LOAD, S_ZERO, S_ZERO, D_T,   1'b0, 1'b0, J_GOTO,    PC_TEST);
            5'd3:  u = mk(OP_MUL,  S_DT,   S_DT,   D_DT2, 1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd4:  u = mk(OP_MUL,  S_V,    S_DT,   D_X,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd5:  u = mk(OP_ADD,  S_P,    S_X,    D_P,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd6:  u = mk(OP_MUL,  S_A,    S_DT2,  D_X,   1'b1, 1'b0, J_NEXT,    PC_INIT);
            5'd7:  u = mk(OP_ADD,  S_P,    S_X,    D_P,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd8:  u = mk(OP_MUL,  S_A,    S_DT,   D_X,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd9:  u = mk(OP_ADD,  S_V,    S_X,    D_V,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd10: u = mk(OP_ADD,  S_T,    S_DT,   D_T,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd11: u = mk(OP_TEST, S_P,    S_RAD,  D_NONE,1'b0, 1'b0, J_IFSTOP,  PC_STOP);
            5'd12: u = mk(OP_MUL,  S_V,    S_V,    D_X,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd13: u = mk(OP_MUL,  S_X,    S_DRAG, D_X,   1'b0, 1'b0, J_IFFIXED, PC_FIXG);
            5'd14: u = mk(OP_UADD, S_RAD,  S_P,    D_Y,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd15: u = mk(OP_MUL,  S_Y,    S_Y,    D_Y,   1'b0, 1'b1, J_NEXT,    PC_INIT);
            5'd16: u = mk(OP_DIV,  S_ISC,  S_Y,    D_Y,   1'b0, 1'b0, J_GOTO,    PC_SUB);
            5'd17: u = mk(OP_LOAD, S_FIXG, S_ZERO, D_Y,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd18: u = mk(OP_SUB,  S_X,    S_Y,    D_X,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd19: u = mk(OP_DIV,  S_X,    S_MASS, D_A,   1'b0, 1'b0, J_END,     PC_INIT);
            5'd20: u = mk(OP_LOAD, S_ZERO, S_ZERO, D_V,   1'b0, 1'b0, J_NEXT,    PC_INIT);
            5'd21: u = mk(OP_LOAD, S_ZERO, S_ZERO, D_A,   1'b0, 1'b0, J_END,     PC_INIT);
            default: u = mk(OP_NOP, S_ZERO, S_ZERO, D_NONE, 1'b0, 1'b0, J_END,   PC_INIT);
        endcase
        return u;
    endfunction

    function automatic word_t mag(input word_t x);
        return x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Returns {clip, value}.
    function automatic logic [WORD_W:0] from_mag(input logic neg, input word_t hi,
                                                  input word_t lo);
        word_t lim;
        word_t v;
        logic  clip;
        lim  = neg ? NEG_MAX : POS_MAX;
        clip = (hi != '0) || (lo > lim);
        v    = clip ? lim : lo;
        return {clip, neg ? (~v + 1'b1) : v};
    endfunction

    // Saturating add or subtract, returns {clip, value}.
    function automatic logic [WORD_W:0] sat_addsub(input word_t a, input word_t b,
                                                    input logic sub);
        word_t s;
        logic  ovf;
        s   = sub ? (a - b) : (a + b);
        ovf = ((a[WORD_W-1] == (b[WORD_W-1] ^ sub)) && (s[WORD_W-1] != a[WORD_W-1]));
        if (ovf)
        begin
            return {1'b1, a[WORD_W-1] ? NEG_MAX : POS_MAX};
        end
        return {1'b0, s};
    endfunction

endpackage

// ----- hdl/fbis_in_if.sv -----
interface fbis_in_if;
    logic        valid;
    logic        ready;
    logic [62:0] step_length;

    modport source (output valid, output step_length, input ready);
    modport sink   (input valid, input step_length, output ready);
endinterface

// ----- hdl/fbis_out_if.sv -----
interface fbis_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] position_out;
    logic [63:0] velocity_out;
    logic [63:0] acceleration_out;
    logic [63:0] elapsed_time;
    logic        stopped;
    logic        saturated;

    modport source (output valid, output position_out, output velocity_out,
                    output acceleration_out, output elapsed_time, output stopped,
                    output saturated, input ready);
    modport sink   (input valid, input position_out, input velocity_out,
                    input acceleration_out, input elapsed_time, input stopped,
                    input saturated, output ready);
endinterface

// ----- hdl/fbis_ctrl.sv -----
module fbis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fbis_pkg::dp_stat_t stat,
    output fbis_pkg::dp_cmd_t  cmd
);
    import fbis_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            started_reg, started_next;
    uop_t            u;
    logic            accept;

    assign u        = uop_rom(pc_reg);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        started_next = started_reg;
        cmd.capture  = accept;
        cmd.start    = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = u.op;
        cmd.src_a    = u.src_a;
        cmd.src_b    = u.src_b;
        cmd.dst      = u.dst;
        cmd.shift1   = u.shift1;
        cmd.umul     = u.umul;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pc_next    = started_reg ? PC_STEP : PC_INIT;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ST_ISSUE;
                    case (u.jmp)
                        J_NEXT:    pc_next = pc_reg + 1'b1;
                        J_GOTO:    pc_next = u.target;
                        J_IFSTOP:  pc_next = stat.stop ? u.target : pc_reg + 1'b1;
                        J_IFFIXED: pc_next = stat.fixed_mode ? u.target : pc_reg + 1'b1;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    started_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pc_reg      <= PC_INIT;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- hdl/fbis_datapath.sv -----
module fbis_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbis_pkg::dp_cmd_t             cmd,
    output fbis_pkg::dp_stat_t            stat,
    input  logic [fbis_pkg::DT_W-1:0]     step_length,
    input  logic                          cfg_we,
    input  logic [fbis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbis_pkg::WORD_W-1:0]   cfg_data,
    fbis_out_if.source                    res
);
    import fbis_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE   = 5'b00001,
        U_MUL    = 5'b00010,
        U_MULFIN = 5'b00100,
        U_DIV    = 5'b01000,
        U_DIVFIN = 5'b10000
    } ustate_t;

    // Configuration.
    logic             mode_reg;
    word_t            svel_reg, spos_reg, drag_reg, fixg_reg, isc_reg;
    logic [DT_W-1:0]  mass_reg, radius_reg;

    // Working registers.
    word_t            p_reg, v_reg, a_reg, t_reg, x_reg, y_reg, dt2_reg;
    logic [DT_W-1:0]  dt_reg;
    logic             clip_reg, stop_reg;

    // Shared multiplier and divider.
    ustate_t          ustate_reg, ustate_next;
    logic             done_reg, done_next;
    word_t            ma_reg, mb_reg;
    logic [2*WORD_W-1:0] acc_reg;
    logic [1:0]       mcnt_reg;
    logic             neg_reg, sh1_reg;
    dst_t             dst_reg;
    logic [2*WORD_W-1:0] num_reg, q_reg;
    word_t            rem_reg, d_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic             out_valid_reg;

    word_t            opa, opb, ma, mb;
    logic             wr_en, wr_clip;
    dst_t             wr_dst;
    word_t            wr_val;
    logic [WORD_W:0]  fm;
    logic [2*WORD_W-1:0] pp_shift, mshift;
    logic [WORD_W-1:0] pp;
    logic             dbit, dtop, dtake;
    word_t            rsh;

    function automatic word_t pick(input src_t s);
        case (s)
            S_P:    return p_reg;
            S_V:    return v_reg;
            S_A:    return a_reg;
            S_T:    return t_reg;
            S_X:    return x_reg;
            S_Y:    return y_reg;
            S_DT:   return {1'b0, dt_reg};
            S_DT2:  return dt2_reg;
            S_DRAG: return drag_reg;
            S_FIXG: return fixg_reg;
            S_ISC:  return isc_reg;
            S_MASS: return {1'b0, mass_reg};
            S_RAD:  return {1'b0, radius_reg};
            S_SPOS: return spos_reg;
            S_SVEL: return svel_reg;
            default: return '0;
        endcase
    endfunction

    assign opa = pick(cmd.src_a);
    assign opb = pick(cmd.src_b);
    assign ma  = cmd.umul ? opa : mag(opa);
    assign mb  = cmd.umul ? opb : mag(opb);

    // One 32x32 partial product per cycle, high halves selected by the count.
    assign pp = 64'(ma_reg[mcnt_reg[1]*32 +: 32]) * 64'(mb_reg[mcnt_reg[0]*32 +: 32]);
    always_comb
    begin
        case (2'(mcnt_reg[1]) + 2'(mcnt_reg[0]))
            2'd0:    pp_shift = {64'b0, pp};
            2'd1:    pp_shift = {32'b0, pp, 32'b0};
            default: pp_shift = {pp, 64'b0};
        endcase
    end
    assign mshift = acc_reg >> (FRAC_BITS + 32'(sh1_reg));

    assign dbit  = num_reg[2*WORD_W-1];
    assign dtop  = rem_reg[WORD_W-1];
    assign rsh   = {rem_reg[WORD_W-2:0], dbit};
    assign dtake = dtop || (rsh >= d_reg);

    always_comb
    begin
        ustate_next = ustate_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_clip     = 1'b0;
        wr_dst      = cmd.dst;
        wr_val      = '0;
        fm          = '0;
        case (ustate_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op)
                        OP_LOAD:
                        begin
                            wr_en = 1'b1; wr_val = opa; done_next = 1'b1;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            fm = sat_addsub(opa, opb, cmd.op == OP_SUB);
                            wr_en = 1'b1; wr_val = fm[WORD_W-1:0]; wr_clip = fm[WORD_W];
                            done_next = 1'b1;
                        end
                        OP_UADD:
                        begin
                            wr_en = 1'b1; wr_val = opa + opb; done_next = 1'b1;
                        end
                        OP_MUL:  ustate_next = U_MUL;
                        OP_DIV:
                        begin
                            if (ma == '0)
                            begin
                                wr_en = 1'b1; wr_val = '0; done_next = 1'b1;
                            end
                            else if (mb == '0)
                            begin
                                // Divide by zero clips towards the numerator's sign.
                                fm = from_mag(opa[WORD_W-1], 64'd1, '0);
                                wr_en = 1'b1; wr_val = fm[WORD_W-1:0]; wr_clip = fm[WORD_W];
                                done_next = 1'b1;
                            end
                            else
                            begin
                                ustate_next = U_DIV;
                            end
                        end
                        default: done_next = 1'b1;
                    endcase
                end
            end
            U_MUL:
            begin
                if (mcnt_reg == 2'd3)
                begin
                    ustate_next = U_MULFIN;
                end
            end
            U_MULFIN:
            begin
                fm = from_mag(neg_reg, mshift[2*WORD_W-1:WORD_W], mshift[WORD_W-1:0]);
                wr_en = 1'b1; wr_dst = dst_reg; wr_val = fm[WORD_W-1:0];
                wr_clip = fm[WORD_W]; done_next = 1'b1;
                ustate_next = U_IDLE;
            end
            U_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    ustate_next = U_DIVFIN;
                end
            end
            U_DIVFIN:
            begin
                fm = from_mag(neg_reg, q_reg[2*WORD_W-1:WORD_W], q_reg[WORD_W-1:0]);
                wr_en = 1'b1; wr_dst = dst_reg; wr_val = fm[WORD_W-1:0];
                wr_clip = fm[WORD_W]; done_next = 1'b1;
                ustate_next = U_IDLE;
            end
            default: ustate_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ustate_reg    <= U_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            svel_reg      <= '0;
            spos_reg      <= '0;
            mass_reg      <= ONE_FX[DT_W-1:0];
            radius_reg    <= ONE_FX[DT_W-1:0];
            drag_reg      <= '0;
            fixg_reg      <= '0;
            isc_reg       <= '0;
        end
        else
        begin
            ustate_reg <= ustate_next;
            done_reg   <= done_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    CFG_SVEL:   svel_reg   <= cfg_data;
                    CFG_SPOS:   spos_reg   <= cfg_data;
                    CFG_MASS:   mass_reg   <= cfg_data[DT_W-1:0];
                    CFG_RADIUS: radius_reg <= cfg_data[DT_W-1:0];
                    CFG_DRAG:   drag_reg   <= cfg_data;
                    CFG_FIXG:   fixg_reg   <= cfg_data;
                    CFG_ISC:    isc_reg    <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg   <= step_length;
            clip_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (wr_en && wr_clip)
        begin
            clip_reg <= 1'b1;
        end
        if (cmd.start && cmd.op == OP_TEST)
        begin
            stop_reg <= mode_reg && (mag(opa) >= opb);
        end
        if (wr_en)
        begin
            case (wr_dst)
                D_P:     p_reg   <= wr_val;
                D_V:     v_reg   <= wr_val;
                D_A:     a_reg   <= wr_val;
                D_T:     t_reg   <= wr_val;
                D_X:     x_reg   <= wr_val;
                D_Y:     y_reg   <= wr_val;
                D_DT2:   dt2_reg <= wr_val;
                default: ;
            endcase
        end
        if (ustate_reg == U_IDLE && cmd.start)
        begin
            ma_reg   <= ma;
            mb_reg   <= mb;
            acc_reg  <= '0;
            mcnt_reg <= '0;
            neg_reg  <= cmd.umul ? 1'b0 : (opa[WORD_W-1] ^ opb[WORD_W-1]);
            sh1_reg  <= cmd.shift1;
            dst_reg  <= cmd.dst;
            num_reg  <= {{WORD_W{1'b0}}, ma} << FRAC_BITS;
            q_reg    <= '0;
            rem_reg  <= '0;
            d_reg    <= mb;
            dcnt_reg <= DCNT_W'(DIV_STEPS - 1);
        end
        if (ustate_reg == U_MUL)
        begin
            acc_reg  <= acc_reg + pp_shift;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (ustate_reg == U_DIV)
        begin
            num_reg  <= {num_reg[2*WORD_W-2:0], 1'b0};
            rem_reg  <= dtake ? (rsh - d_reg) : rsh;
            q_reg    <= {q_reg[2*WORD_W-2:0], dtake};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.load_out)
        begin
            res.position_out     <= p_reg;
            res.velocity_out     <= v_reg;
            res.acceleration_out <= a_reg;
            res.elapsed_time     <= t_reg;
            res.stopped          <= stop_reg;
            res.saturated        <= clip_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign stat.done       = done_reg;
    assign stat.stop       = stop_reg;
    assign stat.fixed_mode = !mode_reg;
    assign stat.out_free   = !out_valid_reg;

endmodule

// ----- hdl/falling_body_integration_step.sv -----
// One-axis falling body integrator in signed Q32.32 with saturation. Each accepted
// request is one time step and yields one result. A step runs through a short
// microprogram on one shared unit. Every micro-op is issued and then waited on until
// it is done: a load, add or compare needs no execution state, a multiply forms four
// 32x32 partial products and then rounds, and a divide runs a restoring divider that
// retires one of 128 quotient bits per cycle, or skips it when the numerator or the
// divisor is zero. The first step after reset loads the start values, later steps
// integrate. Fixed gravity mode skips the inverse-square divide, and a step that
// stops the body skips drag and gravity. A new request is taken once the previous
// result sits in the output register, so it may wait there while the next step
// runs; a step only finishes once that register has been emptied.
module falling_body_integration_step (
    input  logic                           clk,
    input  logic                           rst_n,
    fbis_in_if.sink                        step_in,
    fbis_out_if.source                     state_out,
    input  logic                           cfg_we,
    input  logic [fbis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbis_pkg::WORD_W-1:0]    cfg_data
);
    import fbis_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fbis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step_in.valid),
        .in_ready (step_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbis_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .step_length (step_in.step_length),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res         (state_out)
    );

endmodule

// ----- hdl/fbis_checker.sv -----
module fbis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] position_out,
    input logic [63:0] velocity_out,
    input logic [63:0] acceleration_out,
    input logic        stopped
);

    // A stalled result keeps its position payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position_out))
        else $error("result changed while stalled");

    // One step at a time: the input closes right after a request is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while a step runs");

    // A stopped body reports no motion.
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> velocity_out == 64'd0 && acceleration_out == 64'd0)
        else $error("stopped result with motion");

    // A new result only appears while the input is closed for the step behind it.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a running step");

endmodule

bind falling_body_integration_step fbis_checker u_fbis_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (step_in.valid),
    .in_ready         (step_in.ready),
    .out_valid        (state_out.valid),
    .out_ready        (state_out.ready),
    .position_out     (state_out.position_out),
    .velocity_out     (state_out.velocity_out),
    .acceleration_out (state_out.acceleration_out),
    .stopped          (state_out.stopped)
);

// ----- bench/tb_falling_body_integration_step.sv -----
`timescale 1ns / 100ps

module tb_falling_body_integration_step;
    import fbis_pkg::*;

    typedef struct {
        word_t pos;
        word_t vel;
        word_t acc;
        word_t tim;
        logic  stopped;
        logic  saturated;
    } body_state_t;

    // Predicts the body state after every accepted step and holds it until the result comes.
    class fall_predictor;
        word_t       regs[8];
        bit          started;
        word_t       pos, vel, acc, tim;
        bit          clip;
        body_state_t expected_states[$];
        int          mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[CFG_MASS]   = ONE_FX;
            regs[CFG_RADIUS] = ONE_FX;
            started = 0;
            pos = '0; vel = '0; acc = '0; tim = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, word_t data);
            case (idx)
                CFG_MODE:   regs[idx] = {63'd0, data[0]};
                CFG_MASS,
                CFG_RADIUS: regs[idx] = {1'b0, data[62:0]};
                default:    regs[idx] = data;
            endcase
        endfunction

        function word_t abs_of(word_t x);
            return x[63] ? -x : x;
        endfunction

        function word_t clip_mag(bit neg, logic [127:0] m);
            word_t lim;
            lim = neg ? NEG_MAX : POS_MAX;
            if (m > {64'd0, lim})
            begin
                clip = 1;
                m = {64'd0, lim};
            end
            return neg ? -m[63:0] : m[63:0];
        endfunction

        function word_t mul(word_t a, word_t b, int s);
            logic [127:0] pr;
            pr = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
            return clip_mag(a[63] ^ b[63], pr >> s);
        endfunction

        function word_t div(word_t a, word_t b);
            word_t na, d;
            logic [127:0] q;
            na = abs_of(a);
            d  = abs_of(b);
            if (na == '0)
                return '0;
            if (d == '0)
                return clip_mag(a[63], 128'd1 << 64);
            q = ({64'd0, na} << FRAC_BITS) / {64'd0, d};
            return clip_mag(a[63] ^ b[63], q);
        endfunction

        function word_t add(word_t a, word_t b);
            word_t s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
            begin
                clip = 1;
                return a[63] ? NEG_MAX : POS_MAX;
            end
            return s;
        endfunction

        function word_t sub(word_t a, word_t b);
            word_t s;
            s = a - b;
            if (a[63] != b[63] && s[63] != a[63])
            begin
                clip = 1;
                return a[63] ? NEG_MAX : POS_MAX;
            end
            return s;
        endfunction

        function void note_step(logic [62:0] dt_in);
            word_t dt, dt2, p, v, a, t, drag, grav, u, den;
            logic [127:0] sq;
            bit stop;
            body_state_t r;
            dt = {1'b0, dt_in};
            clip = 0;
            stop = 0;
            if (!started)
            begin
                v = regs[CFG_SVEL];
                p = regs[CFG_SPOS];
                t = '0;
            end
            else
            begin
                dt2 = mul(dt, dt, FRAC_BITS);
                v = add(vel, mul(acc, dt, FRAC_BITS));
                p = add(pos, mul(vel, dt, FRAC_BITS));
                p = add(p, mul(acc, dt2, FRAC_BITS + 1));
                t = add(tim, dt);
            end
            if (regs[CFG_MODE][0] && abs_of(p) >= regs[CFG_RADIUS])
            begin
                stop = 1;
                v = '0;
                a = '0;
            end
            else
            begin
                drag = mul(mul(v, v, FRAC_BITS), regs[CFG_DRAG], FRAC_BITS);
                if (regs[CFG_MODE][0])
                begin
                    u = regs[CFG_RADIUS] + p;
                    sq = {64'd0, u} * {64'd0, u};
                    den = clip_mag(0, sq >> FRAC_BITS);
                    grav = div(regs[CFG_ISC], den);
                end
                else
                    grav = regs[CFG_FIXG];
                a = div(sub(drag, grav), regs[CFG_MASS]);
            end
            started = 1;
            pos = p; vel = v; acc = a; tim = t;
            r.pos = p; r.vel = v; r.acc = a; r.tim = t;
            r.stopped = stop;
            r.saturated = clip;
            expected_states = {expected_states, r};
        endfunction

        function void check_state(body_state_t got);
            body_state_t e;
            if (expected_states.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pos=%h vel=%h", got.pos, got.vel);
                return;
            end
            e = expected_states.pop_front();
            if (got != e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp p=%h v=%h a=%h t=%h st=%b sat=%b",
                              " / got p=%h v=%h a=%h t=%h st=%b sat=%b"},
                             e.pos, e.vel, e.acc, e.tim, e.stopped, e.saturated,
                             got.pos, got.vel, got.acc, got.tim, got.stopped,
                             got.saturated);
            end
        endfunction
    endclass

    logic          clk = 0;
    logic          rst_n = 0;
    logic          cfg_we = 0;
    logic [2:0]    cfg_index = '0;
    word_t         cfg_data = '0;
    int            idle_in = 32;
    int            idle_out = 54;
    int            sent = 0;
    fall_predictor model = new();

    fbis_in_if  step_if();
    fbis_out_if state_if();

    initial
    begin
        step_if.valid = 0;
        step_if.step_length = '0;
        state_if.ready = 0;
    end

    falling_body_integration_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_in   (step_if),
        .state_out (state_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        body_state_t got;
        if (rst_n && state_if.valid && state_if.ready)
        begin
            got.pos = state_if.position_out;
            got.vel = state_if.velocity_out;
            got.acc = state_if.acceleration_out;
            got.tim = state_if.elapsed_time;
            got.stopped = state_if.stopped;
            got.saturated = state_if.saturated;
            model.check_state(got);
        end
        state_if.ready <= ($urandom_range(99) >= idle_out);
    end

    // Caller lowers the write enable after the last write of a batch.
    task automatic write_reg(cfg_idx_t idx, word_t data);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        model.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic send_step(logic [62:0] dt);
        if ($urandom_range(99) < idle_in)
        begin
            step_if.valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_in)
                @(posedge clk);
        end
        step_if.valid <= 1;
        step_if.step_length <= dt;
        do
            @(posedge clk);
        while (!step_if.ready);
        model.note_step(dt);
        sent++;
        if (sent == 290)
        begin
            idle_in = 54;
            idle_out = 32;
        end
        else if (sent == 580)
        begin
            idle_in = 0;
            idle_out = 0;
        end
    endtask

    function automatic word_t rand_word();
        word_t m;
        m = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return m;
            1: return $urandom_range(1) ? POS_MAX : NEG_MAX;
            default:
            begin
                m = m >> $urandom_range(63, 24);
                return $urandom_range(1) ? -m : m;
            end
        endcase
    endfunction

    function automatic word_t rand_positive();
        word_t m;
        m = {$urandom, $urandom};
        m = m >> ($urandom_range(9) == 0 ? 1 : $urandom_range(62, 25));
        return (m == '0) ? word_t'(1) : m;
    endfunction

    function automatic logic [62:0] rand_dt();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(19))
            0: return m[62:0];
            1: return '0;
            2: return '1;
            default: return m[62:0] >> $urandom_range(62, 27);
        endcase
    endfunction

    // Closes the input so the last request is not taken twice, then lets the block empty.
    task automatic wait_drained();
        step_if.valid <= 0;
        while (model.expected_states.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [62:0] dirs[$];
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // First step runs from a very fast start so drag saturates immediately.
        write_reg(CFG_MODE, word_t'(0));
        write_reg(CFG_SVEL, POS_MAX);
        write_reg(CFG_SPOS, NEG_MAX);
        write_reg(CFG_MASS, ONE_FX);
        write_reg(CFG_RADIUS, ONE_FX);
        write_reg(CFG_DRAG, word_t'(64'h0000_0000_8000_0000));
        write_reg(CFG_FIXG, word_t'(64'h0000_0009_CCCC_CCCD));
        write_reg(CFG_ISC, ONE_FX);
        cfg_we <= 0;
        dirs = '{63'd5, 63'd0, 63'd1, '1, 63'h1_0000_0000, 63'h0_8000_0000,
                 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 63'h0_0100_0000,
                 63'h0_0010_0000};
        foreach (dirs[i])
            send_step(dirs[i]);
        wait_drained();

        // Inverse-square gravity: a tiny radius with the body outside it, then a huge one.
        write_reg(CFG_MODE, word_t'(1));
        write_reg(CFG_RADIUS, word_t'(1));
        write_reg(CFG_ISC, NEG_MAX);
        cfg_we <= 0;
        send_step(63'h1_0000_0000);
        send_step('1);
        wait_drained();
        write_reg(CFG_RADIUS, POS_MAX);
        write_reg(CFG_ISC, POS_MAX);
        write_reg(CFG_MASS, POS_MAX);
        cfg_we <= 0;
        for (int i = 0; i < 8; i++)
            send_step(i[0] ? 63'h0_4000_0000 : rand_dt());
        wait_drained();

        for (int ph = 0; ph < 7; ph++)
        begin
            int runs;
            write_reg(CFG_MODE, word_t'(ph % 2));
            case (ph)
                2:
                begin
                    write_reg(CFG_DRAG, POS_MAX);
                    write_reg(CFG_FIXG, NEG_MAX);
                    write_reg(CFG_MASS, word_t'(1));
                end
                5:
                begin
                    write_reg(CFG_DRAG, NEG_MAX);
                    write_reg(CFG_FIXG, POS_MAX);
                    write_reg(CFG_RADIUS, word_t'(1));
                    write_reg(CFG_ISC, NEG_MAX);
                end
                default:
                begin
                    write_reg(CFG_DRAG, rand_word());
                    write_reg(CFG_FIXG, rand_word());
                    write_reg(CFG_MASS, rand_positive());
                    write_reg(CFG_RADIUS, rand_positive());
                    write_reg(CFG_ISC, rand_word());
                end
            endcase
            write_reg(CFG_SVEL, rand_word());
            write_reg(CFG_SPOS, rand_word());
            cfg_we <= 0;
            runs = 0;
            while (runs < 118)
            begin
                send_step(rand_dt());
                runs++;
            end
            wait_drained();
        end

        while (model.expected_states.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (model.mismatches == 0 && model.expected_states.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- falling_body_integration_step.f -----
hdl/fbis_pkg.sv
hdl/fbis_in_if.sv
hdl/fbis_out_if.sv
hdl/fbis_ctrl.sv
hdl/fbis_datapath.sv
hdl/falling_body_integration_step.sv
hdl/fbis_checker.sv
bench/tb_falling_body_integration_step.sv
